@@ hdl/itrd_pkg.sv @@
// Shared constants, types and character-alphabet functions for the radix digit converter.
package itrd_pkg;

  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned RADIX_W     = 9;
  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned CNT_W       = $clog2(VALUE_WIDTH + 1);
  localparam int unsigned ADDR_W      = $clog2(VALUE_WIDTH);

  localparam logic [RADIX_W-1:0] RADIX_MIN = 9'd2;
  localparam logic [RADIX_W-1:0] RADIX_B32 = 9'd32;
  localparam logic [RADIX_W-1:0] RADIX_B64 = 9'd64;
  localparam logic [RADIX_W-1:0] RADIX_RAW = 9'd256;

  localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_MINUS   = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_TWO     = 8'h32;
  localparam logic [CHAR_W-1:0] CHAR_PLUS    = 8'h2B;
  localparam logic [CHAR_W-1:0] CHAR_SLASH   = 8'h2F;

  typedef struct packed {
    logic                   done;
    logic [VALUE_WIDTH-1:0] quotient;
    logic [RADIX_W-1:0]     remainder;
  } div_res_t;

  function automatic logic [CHAR_W-1:0] alpha32(input logic [4:0] idx);
    logic [CHAR_W-1:0] code;
    if (idx < 5'd26) begin
      code = CHAR_UPPER_A + {3'b000, idx};
    end else begin
      code = CHAR_TWO + {3'b000, idx} - 8'd26;
    end
    return code;
  endfunction

  function automatic logic [CHAR_W-1:0] alpha64(input logic [5:0] idx);
    logic [CHAR_W-1:0] code;
    if (idx < 6'd26) begin
      code = CHAR_UPPER_A + {2'b00, idx};
    end else if (idx < 6'd52) begin
      code = CHAR_LOWER_A + {2'b00, idx} - 8'd26;
    end else if (idx < 6'd62) begin
      code = CHAR_ZERO + {2'b00, idx} - 8'd52;
    end else if (idx == 6'd62) begin
      code = CHAR_PLUS;
    end else begin
      code = CHAR_SLASH;
    end
    return code;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_code(input logic [RADIX_W-1:0] rem,
                                                   input logic [RADIX_W-1:0] base);
    logic [CHAR_W-1:0] code;
    case (base)
      RADIX_B32: code = alpha32(rem[4:0]);
      RADIX_B64: code = alpha64(rem[5:0]);
      RADIX_RAW: code = rem[CHAR_W-1:0];
      default: begin
        if (rem > 9'd9) begin
          code = rem[CHAR_W-1:0] + CHAR_LOWER_A - 8'd10;
        end else begin
          code = rem[CHAR_W-1:0] + CHAR_ZERO;
        end
      end
    endcase
    return code;
  endfunction

endpackage

@@ hdl/itrd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module itrd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/itrd_div.sv @@
// Bit-serial restoring divider: one quotient bit per cycle.
module itrd_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [itrd_pkg::VALUE_WIDTH-1:0] dividend_i,
  input  logic [itrd_pkg::RADIX_W-1:0]     divisor_i,
  output itrd_pkg::div_res_t               res_o
);
  import itrd_pkg::*;

  logic                   busy_q;
  logic                   done_q;
  logic [CNT_W-1:0]       cnt_q;
  logic [VALUE_WIDTH-1:0] quo_q;
  logic [RADIX_W-1:0]     rem_q;
  logic [RADIX_W:0]       trial;
  logic                   fits;

  assign trial = {rem_q, quo_q[VALUE_WIDTH-1]};
  assign fits  = trial >= {1'b0, divisor_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(VALUE_WIDTH - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      quo_q <= {quo_q[VALUE_WIDTH-2:0], fits};
      rem_q <= fits ? RADIX_W'(trial - {1'b0, divisor_i}) : trial[RADIX_W-1:0];
    end
  end

  assign res_o.done      = done_q;
  assign res_o.quotient  = quo_q;
  assign res_o.remainder = rem_q;

endmodule

@@ hdl/integer_to_radix_digits.sv @@
// Signed integer to radix numeral converter, one character per output word.
// A value is taken only while the block is idle. Its magnitude is divided by the base
// repeatedly in a bit-serial divider; each digit takes a start, 32 divide steps and a store,
// for up to 32 digits. A negative value then emits a leading minus. The digits are read back
// from a 32-entry digit RAM most significant first, each through the read, fetch and output
// states. A zero value gives a single '0'. Each output word waits in the output register
// until taken; last marks the final character of the numeral.
module integer_to_radix_digits (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic signed [itrd_pkg::VALUE_WIDTH-1:0] number_i,
  input  logic [itrd_pkg::RADIX_W-1:0]            radix_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic [itrd_pkg::CHAR_W-1:0]             digit_char_o,
  output logic                                   last_o
);
  import itrd_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_DIV,
    ST_READ,
    ST_FETCH,
    ST_OUT
  } state_e;

  state_e                 state_q;
  logic                   neg_q;
  logic [VALUE_WIDTH-1:0] mag_q;
  logic [RADIX_W-1:0]     radix_q;
  logic [CNT_W-1:0]       cnt_q;
  logic [CHAR_W-1:0]      char_q;
  logic                   last_q;

  logic [VALUE_WIDTH-1:0] mag_in;
  logic [CNT_W-1:0]       cnt_dec;
  logic                   div_start;
  logic                   wr_en;
  logic [CHAR_W-1:0]      wr_char;
  logic [CHAR_W-1:0]      rd_char;
  div_res_t               div_res;

  assign mag_in    = number_i[VALUE_WIDTH-1] ? (VALUE_WIDTH'(0) - VALUE_WIDTH'(number_i))
                                             : VALUE_WIDTH'(number_i);
  assign cnt_dec   = cnt_q - CNT_W'(1);
  assign div_start = (state_q == ST_START);
  assign wr_en     = (state_q == ST_DIV) && div_res.done;
  assign wr_char   = digit_code(div_res.remainder, radix_q);

  itrd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (mag_q),
    .divisor_i  (radix_q),
    .res_o      (div_res)
  );

  itrd_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (VALUE_WIDTH)
  ) u_digit_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (cnt_q[ADDR_W-1:0]),
    .wdata_i (wr_char),
    .raddr_i (cnt_dec[ADDR_W-1:0]),
    .rdata_o (rd_char)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      neg_q   <= 1'b0;
      mag_q   <= '0;
      radix_q <= RADIX_MIN;
      cnt_q   <= '0;
      char_q  <= '0;
      last_q  <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            neg_q   <= number_i[VALUE_WIDTH-1];
            mag_q   <= mag_in;
            radix_q <= (radix_i < RADIX_MIN) ? RADIX_MIN : radix_i;
            cnt_q   <= '0;
            if (mag_in == '0) begin
              char_q  <= CHAR_ZERO;
              last_q  <= 1'b1;
              state_q <= ST_OUT;
            end else begin
              state_q <= ST_START;
            end
          end
        end
        ST_START: begin
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          if (div_res.done) begin
            cnt_q <= cnt_q + CNT_W'(1);
            mag_q <= div_res.quotient;
            if ((div_res.quotient == '0) || (cnt_q == CNT_W'(VALUE_WIDTH - 1))) begin
              if (neg_q) begin
                char_q  <= CHAR_MINUS;
                last_q  <= 1'b0;
                state_q <= ST_OUT;
              end else begin
                state_q <= ST_READ;
              end
            end else begin
              state_q <= ST_START;
            end
          end
        end
        ST_READ: begin
          state_q <= ST_FETCH;
        end
        ST_FETCH: begin
          char_q  <= rd_char;
          last_q  <= (cnt_q == CNT_W'(1));
          cnt_q   <= cnt_dec;
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (out_ready_i) begin
            state_q <= last_q ? ST_IDLE : ST_READ;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o   = (state_q == ST_IDLE);
  assign out_valid_o  = (state_q == ST_OUT);
  assign digit_char_o = char_q;
  assign last_o       = last_q;

`ifndef SYNTHESIS
  a_wr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (cnt_q < CNT_W'(VALUE_WIDTH)))
    else $error("digit write beyond store depth");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("new word taken while a numeral is in progress");

  a_more_after_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !last_o) |=> !in_ready_o)
    else $error("input reopened before final character");

  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_res.done |-> (state_q == ST_DIV))
    else $error("divider finished outside divide phase");
`endif

endmodule

@@ dv/testbench.sv @@
// Testbench for integer_to_radix_digits: directed and random values checked by a scoreboard.
`timescale 1ns / 100ps

module testbench;
  import itrd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 4000000;
  localparam int unsigned DRAIN_CYCLES = 1200;
  localparam int unsigned RANDOM_WORDS = 450;

  class numeral_tracker;
    typedef struct {
      logic [CHAR_W-1:0] code;
      logic              last;
    } char_word_t;

    char_word_t  pending_chars[$];
    int unsigned mismatches;
    string       b32_alphabet;
    string       b64_alphabet;

    function new();
      b32_alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZ234567";
      b64_alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
      mismatches = 0;
    endfunction

    function logic [CHAR_W-1:0] char_for(int unsigned rem, int unsigned base);
      int unsigned code;
      if (base == RADIX_B32) begin
        return b32_alphabet[rem];
      end
      if (base == RADIX_B64) begin
        return b64_alphabet[rem];
      end
      if (base == RADIX_RAW) begin
        return rem[CHAR_W-1:0];
      end
      if (rem > 9) begin
        code = rem - 10 + CHAR_LOWER_A;
      end else begin
        code = rem + CHAR_ZERO;
      end
      return code[CHAR_W-1:0];
    endfunction

    function void note_value(logic [VALUE_WIDTH-1:0] number, logic [RADIX_W-1:0] radix);
      bit [VALUE_WIDTH-1:0] mag;
      int unsigned          base;
      bit                   neg;
      logic [CHAR_W-1:0]    digits[$];
      char_word_t           w;
      base = 32'((radix < RADIX_MIN) ? RADIX_MIN : radix);
      neg = number[VALUE_WIDTH-1];
      mag = number;
      if (neg) begin
        mag = 0 - mag;
      end
      if (mag == 0) begin
        w = '{CHAR_ZERO, 1'b1};
        pending_chars.push_back(w);
        return;
      end
      while (mag != 0) begin
        digits.push_front(char_for(mag % base, base));
        mag = mag / base;
      end
      if (neg) begin
        w = '{CHAR_MINUS, 1'b0};
        pending_chars.push_back(w);
      end
      foreach (digits[i]) begin
        w.code = digits[i];
        w.last = (i == digits.size() - 1);
        pending_chars.push_back(w);
      end
    endfunction

    function void check_char(logic [CHAR_W-1:0] code, logic last);
      char_word_t want;
      if (pending_chars.size() == 0) begin
        $error("digit_char: expected none, actual %h", code);
        mismatches++;
        return;
      end
      want = pending_chars.pop_front();
      if (want.code !== code) begin
        $error("digit_char: expected %h, actual %h", want.code, code);
        mismatches++;
      end
      if (want.last !== last) begin
        $error("last: expected %b, actual %b", want.last, last);
        mismatches++;
      end
    endfunction

    function int unsigned outstanding();
      return pending_chars.size();
    endfunction
  endclass

  logic                          clk_i;
  logic                          rst_ni = 1'b0;
  logic                          in_valid_i = 1'b0;
  logic                          in_ready_o;
  logic signed [VALUE_WIDTH-1:0] number_i = '0;
  logic [RADIX_W-1:0]            radix_i = RADIX_MIN;
  logic                          out_valid_o;
  logic                          out_ready_i = 1'b0;
  logic [CHAR_W-1:0]             digit_char_o;
  logic                          last_o;

  numeral_tracker numerals = new();
  bit             steady = 1'b0;
  int unsigned    cycle_count = 0;

  integer_to_radix_digits DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .number_i     (number_i),
    .radix_i      (radix_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .digit_char_o (digit_char_o),
    .last_o       (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_ready_i <= steady || ($urandom_range(99) >= 24);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      numerals.check_char(digit_char_o, last_o);
    end
  end

  task automatic send_value(input logic [VALUE_WIDTH-1:0] number,
                            input logic [RADIX_W-1:0] radix);
    while (!steady && $urandom_range(99) < 24) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    number_i   <= number;
    radix_i    <= radix;
    do begin
      @(posedge clk_i);
    end while (!in_ready_o);
    numerals.note_value(number, radix);
    @(negedge clk_i);
  endtask

  initial begin
    logic [VALUE_WIDTH-1:0] number;
    logic [RADIX_W-1:0]     radix;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_value(32'd0, 9'd10);
    send_value(32'h8000_0000, 9'd2);
    send_value(32'h7FFF_FFFF, 9'd2);
    send_value(32'hFFFF_FFFF, 9'd10);
    send_value(32'd255, RADIX_RAW);
    send_value(32'h8000_0000, RADIX_RAW);
    send_value(32'h7FFF_FFFF, RADIX_B32);
    send_value(-32'sd12345, RADIX_B64);
    send_value(32'd63, RADIX_B64);
    send_value(32'd31, RADIX_B32);
    send_value(32'd5, 9'd0);
    send_value(-32'sd5, 9'd1);
    send_value(32'h7FFF_FFFF, 9'd511);
    send_value(32'd1000, 9'd257);
    send_value(32'd35, 9'd36);
    send_value(32'hDEAD_BEEF, 9'd16);
    send_value(32'd0, RADIX_RAW);
    send_value(32'd0, RADIX_B32);
    send_value(32'd10, 9'd11);
    send_value(32'd100, 9'd300);
    send_value(32'hFFFF_FFFF, 9'd0);
    send_value(32'h8000_0000, 9'd511);

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      steady = (i >= 150 && i < 230);
      case ($urandom_range(5))
        0, 1: number = $urandom;
        2: number = $urandom_range(1000);
        3: number = 0 - $urandom_range(1000);
        4: number = $urandom_range(1) ? 32'h8000_0000 + $urandom_range(3)
                                      : 32'h7FFF_FFFF - $urandom_range(3);
        default: begin
          number = $urandom >> $urandom_range(31);
          if ($urandom_range(1)) begin
            number = 0 - number;
          end
        end
      endcase
      case ($urandom_range(7))
        0: radix = RADIX_W'($urandom_range(16, 2));
        1: radix = RADIX_B32;
        2: radix = RADIX_B64;
        3: radix = RADIX_RAW;
        4: radix = RADIX_W'($urandom_range(1));
        5: radix = RADIX_W'($urandom_range(255, 17));
        6: radix = RADIX_W'($urandom_range(511, 257));
        default: radix = RADIX_W'($urandom_range(511));
      endcase
      send_value(number, radix);
    end
    steady = 1'b0;
    in_valid_i <= 1'b0;

    while (numerals.outstanding() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (numerals.mismatches == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
